// ===== rtl/hjc_pkg.sv =====
// Package with jamo codes, combination table and class tests for the Hangul composer.
`timescale 1ns / 1ps
`default_nettype none
package hjc_pkg;

  localparam logic [15:0] JamoBase = 16'h3130;
  localparam logic [15:0] JamoFirst = 16'h3131;
  localparam logic [15:0] JamoLast = 16'h3163;
  localparam logic [6:0] FinalBit = 7'h40;
  localparam logic [5:0] LastRow = 6'd51;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_BKSP  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef struct packed {
    logic [6:0] ini;
    logic [6:0] med;
    logic [6:0] fin;
  } syl_t;

  typedef struct packed {
    logic       accepted;
    logic       commit_valid;
    syl_t       commit;
    logic       preedit_valid;
    syl_t       preedit;
  } res_t;

  function automatic logic [17:0] comb_row(input logic [5:0] i);
    logic [17:0] r;
    begin
      r = '0;
      unique case (i)
        6'd1: r = {6'd1, 6'd0, 6'd1};
        6'd2: r = {6'd1, 6'd1, 6'd2};
        6'd3: r = {6'd1, 6'd21, 6'd2};
        6'd4: r = {6'd4, 6'd0, 6'd1};
        6'd5: r = {6'd4, 6'd24, 6'd2};
        6'd6: r = {6'd4, 6'd30, 6'd2};
        6'd7: r = {6'd7, 6'd0, 6'd1};
        6'd8: r = {6'd7, 6'd7, 6'd1};
        6'd9: r = {6'd9, 6'd0, 6'd1};
        6'd10: r = {6'd9, 6'd1, 6'd2};
        6'd11: r = {6'd9, 6'd17, 6'd2};
        6'd12: r = {6'd9, 6'd18, 6'd2};
        6'd13: r = {6'd9, 6'd21, 6'd2};
        6'd14: r = {6'd9, 6'd28, 6'd2};
        6'd15: r = {6'd9, 6'd29, 6'd2};
        6'd16: r = {6'd9, 6'd30, 6'd2};
        6'd17: r = {6'd17, 6'd0, 6'd1};
        6'd18: r = {6'd18, 6'd0, 6'd1};
        6'd19: r = {6'd18, 6'd18, 6'd1};
        6'd20: r = {6'd18, 6'd21, 6'd2};
        6'd21: r = {6'd21, 6'd0, 6'd1};
        6'd22: r = {6'd21, 6'd21, 6'd2};
        6'd23: r = {6'd23, 6'd0, 6'd1};
        6'd24: r = {6'd24, 6'd0, 6'd1};
        6'd25: r = {6'd24, 6'd24, 6'd1};
        6'd26: r = {6'd26, 6'd0, 6'd1};
        6'd27: r = {6'd27, 6'd0, 6'd1};
        6'd28: r = {6'd28, 6'd0, 6'd1};
        6'd29: r = {6'd29, 6'd0, 6'd1};
        6'd30: r = {6'd30, 6'd0, 6'd1};
        6'd31: r = {6'd31, 6'd0, 6'd1};
        6'd32: r = {6'd32, 6'd0, 6'd1};
        6'd33: r = {6'd33, 6'd0, 6'd1};
        6'd34: r = {6'd34, 6'd0, 6'd1};
        6'd35: r = {6'd35, 6'd0, 6'd1};
        6'd36: r = {6'd36, 6'd0, 6'd1};
        6'd37: r = {6'd37, 6'd0, 6'd1};
        6'd38: r = {6'd38, 6'd0, 6'd1};
        6'd39: r = {6'd39, 6'd0, 6'd1};
        6'd40: r = {6'd39, 6'd31, 6'd2};
        6'd41: r = {6'd39, 6'd32, 6'd2};
        6'd42: r = {6'd39, 6'd51, 6'd2};
        6'd43: r = {6'd43, 6'd0, 6'd1};
        6'd44: r = {6'd44, 6'd0, 6'd1};
        6'd45: r = {6'd44, 6'd35, 6'd2};
        6'd46: r = {6'd44, 6'd36, 6'd2};
        6'd47: r = {6'd44, 6'd51, 6'd2};
        6'd48: r = {6'd48, 6'd0, 6'd1};
        6'd49: r = {6'd49, 6'd0, 6'd1};
        6'd50: r = {6'd49, 6'd51, 6'd2};
        6'd51: r = {6'd51, 6'd0, 6'd1};
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic is_ini(input logic [6:0] v);
    begin
      return (v >= 7'd1) && (v <= 7'd30) && !(v == 7'd3 || v == 7'd5 || v == 7'd6 ||
             (v >= 7'd10 && v <= 7'd16) || v == 7'd20);
    end
  endfunction

  function automatic logic is_med(input logic [6:0] v);
    begin
      return (v >= 7'd31) && (v <= 7'd51);
    end
  endfunction

  function automatic logic is_fin(input logic [6:0] v);
    logic [6:0] l;
    begin
      l = v - FinalBit;
      return (v >= 7'h41) && (v <= 7'h5e) && !(l == 7'd8 || l == 7'd19 || l == 7'd25);
    end
  endfunction

  // Rows for a given base are contiguous starting at the base index.
  function automatic logic [6:0] combine(input logic [6:0] first, input logic [6:0] second);
    logic [5:0] fc;
    logic [5:0] sc;
    logic [5:0] r;
    logic [17:0] row;
    logic       run;
    logic [5:0] idx;
    begin
      fc = first[5:0];
      sc = second[5:0];
      r = '0;
      run = 1'b1;
      for (int k = 0; k < 8; k++) begin
        idx = fc + 6'(k);
        row = comb_row(idx);
        if (run && (idx <= LastRow) && (row[17:12] == fc)) begin
          if (row[11:6] == sc) begin
            r = idx;
            run = 1'b0;
          end
        end else begin
          run = 1'b0;
        end
      end
      return {1'b0, r} | (first & FinalBit);
    end
  endfunction

  function automatic logic [6:0] moved_part(input logic [6:0] prev, input logic [6:0] fin);
    logic [5:0] pi;
    logic [5:0] ji;
    logic [17:0] rp;
    logic [17:0] rj;
    logic [6:0] r;
    begin
      pi = prev[5:0];
      ji = fin[5:0];
      rp = comb_row(pi);
      rj = comb_row(ji);
      r = '0;
      if (prev == '0) begin
        r = {1'b0, ji};
      end else if (pi <= LastRow && ji <= LastRow) begin
        if (rj[5:0] == rp[5:0]) r = {1'b0, rj[17:12]};
        else if (rj[5:0] == rp[5:0] + 6'd1) r = {1'b0, rj[11:6]};
        else if (rj[5:0] == rp[5:0] + 6'd2) r = {1'b0, ji};
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hangul_jamo_composer.sv =====
// Top level of the Hangul two-set jamo composer with stream ports.
// An accepted request's result is in the output register in the next cycle.
// One request per cycle unless stalled; the composer state updates in a single pass.
// The output register frees on take, so a request is taken while the previous result waits
// only if the consumer takes it in the same cycle.
// Reset clears the syllable slots, the key stack and the output valid at once.
`timescale 1ns / 1ps
`default_nettype none
module hangul_jamo_composer #(
  parameter int unsigned STACK_DEPTH = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: opcode[1:0], key_code[17:2], zero [23:18]
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: accepted, commit_valid, commit_initial, commit_medial, commit_final,
  //        preedit_valid, preedit_initial, preedit_medial, preedit_final, zero [47:45]
  output logic [47:0]      m_axis_tdata
);
  import hjc_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  syl_t                         syl_q;
  syl_t                         syl_d;
  logic [STACK_DEPTH-1:0][6:0]  stack_q;
  logic [STACK_DEPTH-1:0][6:0]  stack_d;
  logic [CntW-1:0]              cnt_q;
  logic [CntW-1:0]              cnt_d;
  res_t                         res_d;
  res_t                         res_q;
  logic                         vld_q;
  logic                         take;

  assign s_axis_tready = !vld_q || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;

  hjc_core #(
    .StackDepth(STACK_DEPTH),
    .CntW(CntW)
  ) u_core (
    .opcode_i  (s_axis_tdata[1:0]),
    .key_code_i(s_axis_tdata[17:2]),
    .cur_i     (syl_q),
    .stack_i   (stack_q),
    .cnt_i     (cnt_q),
    .nxt_o     (syl_d),
    .stack_o   (stack_d),
    .cnt_o     (cnt_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      syl_q <= '0;
      stack_q <= '0;
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (take) begin
        syl_q <= syl_d;
        stack_q <= stack_d;
        cnt_q <= cnt_d;
        vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata = {3'd0,
                         res_q.preedit.fin, res_q.preedit.med, res_q.preedit.ini,
                         res_q.preedit_valid,
                         res_q.commit.fin, res_q.commit.med, res_q.commit.ini,
                         res_q.commit_valid, res_q.accepted};

endmodule
`default_nettype wire

// ===== rtl/hjc_core.sv =====
// Next-state and result logic of the composer for one request.
`timescale 1ns / 1ps
`default_nettype none
module hjc_core #(
  parameter int unsigned StackDepth = 12,
  parameter int unsigned CntW = $clog2(StackDepth + 1)
) (
  input  wire logic [1:0]            opcode_i,
  input  wire logic [15:0]           key_code_i,
  input  wire hjc_pkg::syl_t         cur_i,
  input  wire logic [StackDepth-1:0][6:0] stack_i,
  input  wire logic [CntW-1:0]       cnt_i,
  output hjc_pkg::syl_t              nxt_o,
  output logic [StackDepth-1:0][6:0] stack_o,
  output logic [CntW-1:0]            cnt_o,
  output hjc_pkg::res_t              res_o
);
  import hjc_pkg::*;

  localparam logic [CntW-1:0] Depth = CntW'(StackDepth);

  syl_t                        s;
  logic [StackDepth-1:0][6:0]  st;
  logic [CntW-1:0]             c;
  logic                        acc;
  logic                        cv;
  syl_t                        cs;
  logic [6:0]                  ch;
  logic [6:0]                  comb;
  logic [6:0]                  top;
  logic [6:0]                  nx;
  logic [6:0]                  mv;
  logic [6:0]                  pv;
  logic [6:0]                  pw;
  logic [6:0]                  bch;
  logic [6:0]                  bnx;
  logic                        do_commit;
  logic                        keep_fin;
  logic [6:0]                  fin_set;

  function automatic logic [6:0] peek_at(input logic [StackDepth-1:0][6:0] a,
                                         input logic [CntW-1:0] n);
    logic [6:0] r;
    begin
      r = '0;
      for (int k = 0; k < StackDepth; k++) begin
        if (n == CntW'(k + 1)) r = a[k];
      end
      return r;
    end
  endfunction

  always_comb begin
    s = cur_i;
    st = stack_i;
    c = cnt_i;
    acc = 1'b0;
    cv = 1'b0;
    cs = '0;
    ch = '0;
    comb = '0;
    top = peek_at(stack_i, cnt_i);
    nx = '0;
    mv = '0;
    pv = '0;
    pw = '0;
    bch = '0;
    bnx = '0;
    do_commit = 1'b0;
    keep_fin = 1'b0;
    fin_set = '0;
    if (key_code_i >= JamoFirst && key_code_i <= JamoLast) begin
      ch = 7'(key_code_i - JamoBase);
    end
    unique case (op_e'(opcode_i))
      OP_KEY: begin
        acc = 1'b1;
        if (ch == '0) begin
          do_commit = 1'b1;
        end else if (s.fin != '0) begin
          if (is_ini(ch)) begin
            comb = combine(s.fin, ch | FinalBit);
            if (is_fin(comb)) pv = comb;
            else begin
              do_commit = 1'b1;
              pw = ch;
            end
          end else if (is_med(ch)) begin
            nx = (cnt_i >= CntW'(2) && cnt_i <= Depth) ?
                 peek_at(stack_i, cnt_i - CntW'(1)) : '0;
            do_commit = 1'b1;
            if (is_fin(nx)) begin
              mv = moved_part(nx, s.fin);
              if (mv == '0) pw = ch;
              else begin
                keep_fin = 1'b1;
                fin_set = nx;
                pv = mv;
                pw = ch;
              end
            end else begin
              keep_fin = 1'b1;
              fin_set = '0;
              pv = {1'b0, top[5:0]};
              pw = ch;
            end
          end else begin
            do_commit = 1'b1;
            acc = 1'b0;
          end
        end else if (s.med != '0) begin
          if (is_ini(ch)) begin
            if (s.ini != '0) begin
              if (is_fin(ch | FinalBit)) pv = ch | FinalBit;
              else begin
                do_commit = 1'b1;
                pw = ch;
              end
            end else pv = ch;
          end else if (is_med(ch)) begin
            comb = combine(s.med, ch);
            if (is_med(comb)) pv = comb;
            else begin
              do_commit = 1'b1;
              pw = ch;
            end
          end else begin
            do_commit = 1'b1;
            acc = 1'b0;
          end
        end else if (s.ini != '0) begin
          if (is_ini(ch)) begin
            comb = combine(s.ini, ch);
            if (is_ini(comb)) pv = comb;
            else begin
              do_commit = 1'b1;
              pw = ch;
            end
          end else pv = ch;
        end else begin
          pv = ch;
        end
        if (keep_fin) s.fin = fin_set;
        if (do_commit) begin
          if (s.ini != '0 || s.med != '0 || s.fin != '0) begin
            cv = 1'b1;
            cs = s;
          end
          s = '0;
          st = '0;
          c = '0;
        end
        for (int p = 0; p < 2; p++) begin
          if (p == 0) bch = pv;
          else bch = pw;
          if (bch != '0) begin
            if (is_ini(bch)) s.ini = bch;
            else if (is_med(bch)) s.med = bch;
            else if (is_fin(bch)) s.fin = bch;
            if (c < Depth) begin
              for (int k = 0; k < StackDepth; k++) begin
                if (c == CntW'(k)) st[k] = bch;
              end
              c = c + CntW'(1);
            end
          end
        end
      end
      OP_BKSP: begin
        if (cnt_i != '0 && cnt_i <= Depth) begin
          bch = top;
          c = cnt_i - CntW'(1);
          if (bch != '0) begin
            if (c == '0) begin
              s = '0;
              acc = 1'b1;
            end else begin
              bnx = peek_at(stack_i, c);
              acc = 1'b1;
              if (is_ini(bch)) s.ini = is_ini(bnx) ? bnx : '0;
              else if (is_med(bch)) s.med = is_med(bnx) ? bnx : '0;
              else if (is_fin(bch)) s.fin = is_fin(bnx) ? bnx : '0;
              else acc = 1'b0;
            end
          end
        end
      end
      OP_FLUSH: begin
        if (s.ini != '0 || s.med != '0 || s.fin != '0) begin
          cv = 1'b1;
          cs = s;
        end
        s = '0;
        st = '0;
        c = '0;
      end
      default: begin
      end
    endcase
    nxt_o = s;
    stack_o = st;
    cnt_o = c;
    res_o.accepted = acc;
    res_o.commit_valid = cv;
    res_o.commit = cs;
    res_o.preedit_valid = (s.ini != '0) || (s.med != '0) || (s.fin != '0);
    res_o.preedit = s;
  end

endmodule
`default_nettype wire

// ===== rtl/hjc_checker.sv =====
// Port-level assertions for the Hangul jamo composer and their binding.
`timescale 1ns / 1ps
`default_nettype none
module hjc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata
);
  a_res_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("no result after request");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_commit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[22:2] == 21'd0)
    else $error("commit fields without commit");
  a_preedit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23] == (m_axis_tdata[44:24] != 21'd0))
    else $error("preedit valid mismatch");
endmodule

bind hangul_jamo_composer hjc_checker u_chk (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
